// File: rtl/core/cas_pkg.sv
// Shared constants and types for the constrained adjacent swap distance block.
// No dependencies; used by cas_cell, cas_chain and the top level.
package cas_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int LETTER_W = 5;
    localparam int ALPHABET = 26;
    localparam int SEEN_W   = 1 << LETTER_W;
    localparam int TOTAL_W  = 20;
    localparam int OUT_W    = 19;
    localparam int FLAG_W   = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [OUT_W-1:0]   OUT_MAX   = {OUT_W{1'b1}};

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_ALLOW  = 2'd1;
    localparam logic [1:0] MODE_SOURCE = 2'd2;
    localparam logic [1:0] MODE_TARGET = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [1:0] STATUS_FORBIDDEN = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    localparam int FLAG_MISMATCH  = 0;
    localparam int FLAG_FORBIDDEN = 1;
    localparam int FLAG_OVERFLOW  = 2;

    // Search token walking down the cell row.
    typedef struct packed {
        logic                active;
        logic                found;
        logic [LETTER_W-1:0] letter;
        logic [IDX_W-1:0]    ahead;
        logic [SEEN_W-1:0]   seen;
    } t_token;

    // Write/clear command to the whole row.
    typedef struct packed {
        logic                clr;
        logic                wen;
        logic [IDX_W-1:0]    idx;
        logic [LETTER_W-1:0] letter;
    } t_row_cmd;

    // Write/clear command to a single cell.
    typedef struct packed {
        logic                clr;
        logic                wen;
        logic [LETTER_W-1:0] letter;
    } t_cell_cmd;

endpackage

// File: rtl/core/cas_cell.sv
// One source cell: holds a letter with valid and consumed marks, and
// processes the search token passing through. Depends on cas_pkg.
module cas_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cas_pkg::t_cell_cmd i_cmd,
    input  cas_pkg::t_token    i_tok,
    output cas_pkg::t_token    o_tok
);
    import cas_pkg::*;

    logic [LETTER_W-1:0] r_letter;
    logic                r_valid;
    logic                r_consumed;
    logic                r_tok_active;
    t_token              r_tok;
    t_token              n_tok;
    logic                w_live;
    logic                w_hit;

    assign w_live = i_tok.active && r_valid && !r_consumed && !i_tok.found;
    assign w_hit  = w_live && (r_letter == i_tok.letter);

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
        end else if (w_live) begin
            n_tok.ahead = i_tok.ahead + IDX_W'(1);
            n_tok.seen  = i_tok.seen | (SEEN_W'(1) << r_letter);
        end
    end

    // Control marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_consumed   <= 1'b0;
            r_tok_active <= 1'b0;
        end else begin
            r_tok_active <= i_tok.active;
            if (i_cmd.clr) begin
                r_valid    <= 1'b0;
                r_consumed <= 1'b0;
            end else if (i_cmd.wen) begin
                r_valid    <= 1'b1;
                r_consumed <= 1'b0;
            end else if (w_hit) begin
                r_consumed <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (i_cmd.wen) begin
            r_letter <= i_cmd.letter;
        end
    end

    always_comb begin
        o_tok        = r_tok;
        o_tok.active = r_tok_active;
    end

endmodule

// File: rtl/core/cas_chain.sv
// Row of MAX_LEN source cells; the token enters at cell 0 and advances one
// cell per cycle. Depends on cas_pkg and cas_cell.
module cas_chain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cas_pkg::t_row_cmd i_row,
    input  cas_pkg::t_token   i_tok,
    output cas_pkg::t_token   o_tok
);
    import cas_pkg::*;

    t_token    w_tok [MAX_LEN+1];
    t_cell_cmd w_cmd [MAX_LEN];

    assign w_tok[0] = i_tok;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        assign w_cmd[k] = '{clr:    i_row.clr,
                            wen:    i_row.wen && (i_row.idx == IDX_W'(k)),
                            letter: i_row.letter};

        cas_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[k]),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign o_tok = w_tok[MAX_LEN];

endmodule

// File: rtl/core/constrained_adjacent_swap_distance.sv
// Top level of the constrained adjacent swap distance block.
// Depends on cas_pkg and cas_chain (which instantiates cas_cell).
//
// Usage:
//   Drive i_mode/i_letter/i_partner_letter/i_last with start high; the
//   transaction is taken at the edge where start is high and busy is low.
//   A job is: one clear, any number of allowed pairs, the source letters,
//   then the target letters, the final one with i_last set.
//   Clear, allow and source transactions leave busy low.
//   A target letter launches a search token into a row of MAX_LEN cells;
//   the token advances one cell per cycle, and a target letter keeps busy
//   high until the token leaves the end of the cell row. A target letter
//   outside the alphabet is not searched and sets the mismatch flag.
//   A final target letter adds a report state; the result then appears on
//   o_swap_total/o_status with o_done high for exactly one cycle, while the
//   block already accepts the next transaction.
//   The receiver cannot stall: o_done is a one-cycle strobe and the result
//   must be captured in that cycle.
//   Reset (i_rst_n low, synchronous) empties the job: no source cells, no
//   allowed pairs, zero total and flags; no result is pending.
module constrained_adjacent_swap_distance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [cas_pkg::LETTER_W-1:0] i_letter,
    input  logic [cas_pkg::LETTER_W-1:0] i_partner_letter,
    input  logic                         i_last,
    output logic                         o_done,
    output logic [cas_pkg::OUT_W-1:0]    o_swap_total,
    output logic [1:0]                   o_status
);
    import cas_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]          r_state;
    logic [ALPHABET-1:0] r_allow [ALPHABET];
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_matched;
    logic [TOTAL_W-1:0]  r_total;
    logic [FLAG_W-1:0]   r_flags;
    logic                r_last_pend;
    logic                r_inj_active;
    t_token              r_inj;
    logic                r_done;
    logic [OUT_W-1:0]    r_swap_total;
    logic [1:0]          r_status;

    logic                w_accept;
    logic                w_src_ok;
    logic                w_tgt_ok;
    t_row_cmd            w_row;
    t_token              w_inj;
    t_token              w_exit;
    logic [SEEN_W-1:0]   w_allow_ext;
    logic [TOTAL_W:0]    w_sum;
    logic [FLAG_W-1:0]   w_final_flags;
    logic [1:0]          w_status;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_src_ok = (r_len < LEN_W'(MAX_LEN));
    assign w_tgt_ok = (i_letter < LETTER_W'(ALPHABET));

    // Row command: clear, or store the next source letter at the fill index
    assign w_row = '{clr:    w_accept && (i_mode == MODE_CLEAR),
                     wen:    w_accept && (i_mode == MODE_SOURCE) && w_src_ok,
                     idx:    r_len[IDX_W-1:0],
                     letter: i_letter};

    always_comb begin
        w_inj        = r_inj;
        w_inj.active = r_inj_active;
    end

    cas_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (w_row),
        .i_tok   (w_inj),
        .o_tok   (w_exit)
    );

    // Token leaving the row: check the letters passed against the allowed set
    assign w_allow_ext = SEEN_W'(r_allow[w_exit.letter]);
    assign w_sum       = {1'b0, r_total} + (TOTAL_W + 1)'(w_exit.ahead);

    // Remaining unconsumed cells at the end of the job are a mismatch
    always_comb begin
        w_final_flags = r_flags;
        if (r_matched != r_len) begin
            w_final_flags[FLAG_MISMATCH] = 1'b1;
        end
    end

    always_comb begin
        if (w_final_flags[FLAG_OVERFLOW]) begin
            w_status = STATUS_OVERFLOW;
        end else if (w_final_flags[FLAG_MISMATCH]) begin
            w_status = STATUS_MISMATCH;
        end else if (w_final_flags[FLAG_FORBIDDEN]) begin
            w_status = STATUS_FORBIDDEN;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // Sequencer and job state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_matched    <= '0;
            r_total      <= '0;
            r_flags      <= '0;
            r_last_pend  <= 1'b0;
            r_inj_active <= 1'b0;
            r_done       <= 1'b0;
            for (int a = 0; a < ALPHABET; a++) begin
                r_allow[a] <= '0;
            end
        end else begin
            r_inj_active <= 1'b0;
            r_done       <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_mode)
                            MODE_CLEAR: begin
                                r_len     <= '0;
                                r_matched <= '0;
                                r_total   <= '0;
                                r_flags   <= '0;
                                for (int a = 0; a < ALPHABET; a++) begin
                                    r_allow[a] <= '0;
                                end
                            end
                            MODE_ALLOW: begin
                                if (w_tgt_ok &&
                                    (i_partner_letter < LETTER_W'(ALPHABET))) begin
                                    r_allow[i_letter][i_partner_letter] <= 1'b1;
                                    r_allow[i_partner_letter][i_letter] <= 1'b1;
                                end
                            end
                            MODE_SOURCE: begin
                                if (w_src_ok) begin
                                    r_len <= r_len + LEN_W'(1);
                                end else begin
                                    r_flags[FLAG_OVERFLOW] <= 1'b1;
                                end
                            end
                            MODE_TARGET: begin
                                r_last_pend <= i_last;
                                if (w_tgt_ok) begin
                                    r_inj_active <= 1'b1;
                                    r_state      <= S_WALK;
                                end else begin
                                    // Letter outside the alphabet never matches
                                    r_flags[FLAG_MISMATCH] <= 1'b1;
                                    if (i_last) begin
                                        r_state <= S_REPORT;
                                    end
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (w_exit.active) begin
                        if (!w_exit.found) begin
                            r_flags[FLAG_MISMATCH] <= 1'b1;
                        end else begin
                            r_matched <= r_matched + LEN_W'(1);
                            if ((w_exit.seen & w_allow_ext) != w_exit.seen) begin
                                r_flags[FLAG_FORBIDDEN] <= 1'b1;
                            end
                            if (w_sum > {1'b0, TOTAL_MAX}) begin
                                r_total <= TOTAL_MAX;
                            end else begin
                                r_total <= w_sum[TOTAL_W-1:0];
                            end
                        end
                        r_state <= r_last_pend ? S_REPORT : S_IDLE;
                    end
                end
                S_REPORT: begin
                    r_flags <= w_final_flags;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Token and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == MODE_TARGET)) begin
            r_inj.active <= 1'b1;
            r_inj.found  <= 1'b0;
            r_inj.letter <= i_letter;
            r_inj.ahead  <= '0;
            r_inj.seen   <= '0;
        end
        if (r_state == S_REPORT) begin
            r_status <= w_status;
            if (w_status != STATUS_OK) begin
                r_swap_total <= '0;
            end else if (r_total > TOTAL_W'(OUT_MAX)) begin
                r_swap_total <= OUT_MAX;
            end else begin
                r_swap_total <= r_total[OUT_W-1:0];
            end
        end
    end

    assign o_done       = r_done;
    assign o_swap_total = r_swap_total;
    assign o_status     = r_status;

    // Consumed cells never outnumber stored cells
    a_matched_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched <= r_len)
        else $error("matched count exceeds source length");

    // A token only leaves the row while a search is in progress
    a_exit_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.active |-> (r_state == S_WALK))
        else $error("token left the row outside a search");

    // A result always follows a report cycle
    a_done_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == S_REPORT)
        else $error("result strobe without report cycle");

    // A failed job reports a zero total
    a_err_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_status != STATUS_OK) |-> (r_swap_total == '0))
        else $error("nonzero total with error status");

    // Injecting a token always enters the search state
    a_inject_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj_active |-> (r_state == S_WALK))
        else $error("token injected outside a search");

endmodule
